/* rtl/assert_macros.svh */
// Assertion macros shared by the touch report parser RTL.
// Included by each module that carries concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// implication property, clocked and disabled during reset
`define TRPP_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("trpp assertion failed");
// condition that must never be true
`define TRPP_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("trpp forbidden condition seen");
`else
`define TRPP_ASSERT(name, clk, rst_n, prop)
`define TRPP_NEVER(name, clk, rst_n, expr)
`endif
`endif

/* rtl/trpp_pkg.sv */
// Package for the touch report point parser: report layout constants,
// result struct and the records-that-fit helper. No dependencies.
package trpp_pkg;

    localparam int OUTPUT_POINT_LIMIT = 10;
    localparam int RECORD_LIMIT       = 10;

    localparam int HDR_BYTES  = 7;
    localparam int REC_BYTES  = 10;
    localparam int BTN_BYTES  = 14;
    localparam int MAX_REPORT = HDR_BYTES + RECORD_LIMIT * REC_BYTES;

    localparam int POS_W = 7;
    localparam int IDX_W = 4;

    localparam logic [7:0]  ID_TOUCH   = 8'h01;
    localparam logic [7:0]  ID_BUTTON  = 8'h03;
    localparam logic [15:0] LEN_NONE   = 16'hFFFF;
    localparam logic [15:0] LEN_MIN    = 16'd3;

    // byte positions within the header
    localparam logic [POS_W-1:0] POS_LEN_LO = 7'd0;
    localparam logic [POS_W-1:0] POS_LEN_HI = 7'd1;
    localparam logic [POS_W-1:0] POS_ID     = 7'd2;
    localparam logic [POS_W-1:0] POS_COUNT  = 7'd5;

    // byte offsets within one record
    localparam logic [3:0] OFF_CLEAR    = 4'd0;
    localparam logic [3:0] OFF_META     = 4'd1;
    localparam logic [3:0] OFF_X_LO     = 4'd2;
    localparam logic [3:0] OFF_X_HI     = 4'd3;
    localparam logic [3:0] OFF_Y_LO     = 4'd4;
    localparam logic [3:0] OFF_Y_HI     = 4'd5;
    localparam logic [3:0] OFF_PRESSURE = 4'd6;
    localparam logic [3:0] OFF_LAST     = 4'(REC_BYTES - 1);

    // x/10 as (x*205)>>11, exact for x below 1024
    localparam int REC_RECIP = 205;
    localparam int REC_SHIFT = 11;

    typedef struct packed {
        logic               has_point;
        logic [IDX_W-1:0]   point_index;
        logic [4:0]         finger_id;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [7:0]         pressure;
        logic               last_point;
    } t_result;

    // whole records that fit behind the header; len is at least HDR_BYTES
    function automatic logic [IDX_W-1:0] records_fit(input logic [POS_W-1:0] len);
        logic [POS_W-1:0]  body;
        logic [14:0]       prod;
        body = len - POS_W'(HDR_BYTES);
        prod = 15'(body) * 15'(REC_RECIP);
        return IDX_W'(prod >> REC_SHIFT);
    endfunction

endpackage

/* rtl/trpp_parser.sv */
// Report parser state and per-byte decode for the touch report point parser.
// Depends on trpp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module trpp_parser
    import trpp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [7:0]  i_byte,
    input  logic        i_start,
    output logic        o_emit,
    output t_result     o_result
);

    logic             r_active, n_active;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_len_lo, n_len_lo;
    logic [POS_W-1:0] r_len, n_len;
    logic [IDX_W-1:0] r_npts, n_npts;
    logic [IDX_W-1:0] r_rec_idx, n_rec_idx;
    logic [3:0]       r_off, n_off;
    logic [7:0]       r_meta, n_meta;
    logic [15:0]      r_x, n_x;
    logic [15:0]      r_y, n_y;

    // start overrides the stored report context
    logic             act;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] len;
    logic [IDX_W-1:0] rec_idx;
    logic [3:0]       off;
    logic [15:0]      full_len;
    logic [POS_W-1:0] clamp_len;
    logic [IDX_W-1:0] fit;
    logic [4:0]       cnt;
    logic             last;

    assign act      = i_start | r_active;
    assign pos      = i_start ? '0 : r_pos;
    assign len      = i_start ? '0 : r_len;
    assign rec_idx  = i_start ? '0 : r_rec_idx;
    assign off      = i_start ? '0 : r_off;
    assign full_len = {i_byte, r_len_lo};
    assign clamp_len = (full_len > 16'(MAX_REPORT)) ? POS_W'(MAX_REPORT)
                                                     : full_len[POS_W-1:0];
    assign fit      = records_fit(len);
    assign last     = (5'(rec_idx) + 5'd1) >= 5'(r_npts);

    always_comb begin
        cnt = i_byte[4:0];
        if (cnt > 5'(fit)) begin
            cnt = 5'(fit);
        end
        if (cnt > 5'(RECORD_LIMIT)) begin
            cnt = 5'(RECORD_LIMIT);
        end
        if (cnt > 5'(OUTPUT_POINT_LIMIT)) begin
            cnt = 5'(OUTPUT_POINT_LIMIT);
        end
    end

    always_comb begin
        n_active  = r_active;
        n_pos     = r_pos;
        n_len_lo  = r_len_lo;
        n_len     = r_len;
        n_npts    = r_npts;
        n_rec_idx = r_rec_idx;
        n_off     = r_off;
        n_meta    = r_meta;
        n_x       = r_x;
        n_y       = r_y;
        o_emit    = 1'b0;
        o_result  = '0;
        o_result.last_point = 1'b1;

        if (i_en && act) begin
            n_active  = 1'b1;
            n_pos     = pos + POS_W'(1);
            n_len     = len;
            n_rec_idx = rec_idx;
            n_off     = off;
            if (i_start) begin
                n_npts = '0;
            end
            if (pos > POS_ID && pos >= len) begin
                n_active = 1'b0;
            end else begin
                case (pos)
                    POS_LEN_LO: n_len_lo = i_byte;
                    POS_LEN_HI: begin
                        n_len = clamp_len;
                        if (full_len == '0 || full_len == LEN_NONE
                            || 16'(clamp_len) < LEN_MIN) begin
                            o_emit   = 1'b1;
                            n_active = 1'b0;
                        end
                    end
                    POS_ID: begin
                        if ((i_byte == ID_BUTTON && len == POS_W'(BTN_BYTES))
                            || i_byte != ID_TOUCH || len < POS_W'(HDR_BYTES)) begin
                            o_emit   = 1'b1;
                            n_active = 1'b0;
                        end
                    end
                    POS_COUNT: begin
                        n_npts    = IDX_W'(cnt);
                        n_rec_idx = '0;
                        if (cnt == '0) begin
                            o_emit   = 1'b1;
                            n_active = 1'b0;
                        end
                    end
                    default: begin
                        if (pos >= POS_W'(HDR_BYTES)) begin
                            n_off = (off == OFF_LAST) ? '0 : off + 4'd1;
                            case (off)
                                OFF_CLEAR: begin
                                    n_meta = '0;
                                    n_x    = '0;
                                    n_y    = '0;
                                end
                                OFF_META:  n_meta      = i_byte;
                                OFF_X_LO:  n_x[7:0]    = i_byte;
                                OFF_X_HI:  n_x[15:8]   = i_byte;
                                OFF_Y_LO:  n_y[7:0]    = i_byte;
                                OFF_Y_HI:  n_y[15:8]   = i_byte;
                                OFF_PRESSURE: begin
                                    o_emit               = 1'b1;
                                    o_result.has_point   = 1'b1;
                                    o_result.point_index = rec_idx;
                                    o_result.finger_id   = r_meta[7:3];
                                    o_result.pos_x       = r_x;
                                    o_result.pos_y       = r_y;
                                    o_result.pressure    = i_byte;
                                    o_result.last_point  = last;
                                    n_rec_idx = rec_idx + IDX_W'(1);
                                    if (last) begin
                                        n_active = 1'b0;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_pos     <= '0;
            r_len     <= '0;
            r_npts    <= '0;
            r_rec_idx <= '0;
            r_off     <= '0;
        end else begin
            r_active  <= n_active;
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_npts    <= n_npts;
            r_rec_idx <= n_rec_idx;
            r_off     <= n_off;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len_lo <= n_len_lo;
        r_meta   <= n_meta;
        r_x      <= n_x;
        r_y      <= n_y;
    end

    `TRPP_ASSERT(a_pos_bounded, i_clk, i_rst_n, r_active |-> r_pos <= POS_W'(MAX_REPORT))
    `TRPP_ASSERT(a_npts_limit, i_clk, i_rst_n, 1'b1 |-> r_npts <= IDX_W'(OUTPUT_POINT_LIMIT))
    `TRPP_ASSERT(a_point_in_range, i_clk, i_rst_n,
        (o_emit && o_result.has_point) |-> o_result.point_index < r_npts)
    `TRPP_ASSERT(a_emit_ends_empty, i_clk, i_rst_n,
        (o_emit && !o_result.has_point) |=> !r_active)

endmodule

/* rtl/trpp_out_reg.sv */
// Result holding register for the touch report point parser output channel.
// Depends on trpp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module trpp_out_reg
    import trpp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid, n_valid;
    t_result r_result;

    // free when empty or when the held item leaves this cycle
    assign o_free  = !r_valid || !i_stall;
    assign n_valid = i_load || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    `TRPP_NEVER(a_no_overwrite, i_clk, i_rst_n, i_load && r_valid && i_stall)
    `TRPP_ASSERT(a_held_under_stall, i_clk, i_rst_n,
        (r_valid && i_stall) |=> (r_valid && $stable(r_result)))
    `TRPP_ASSERT(a_load_shows, i_clk, i_rst_n, i_load |=> r_valid)

endmodule

/* rtl/touch_report_point_parser.sv */
// Top level of the touch report point parser: input register, parser, output register.
// Depends on trpp_pkg, trpp_parser, trpp_out_reg and assert_macros.svh.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_data_byte, i_report_start
//  out     | output    | o_out_valid / i_out_stall| o_has_point .. o_last_point
//
// One byte per cycle sustained unless a full output register stalls; o_out_valid is registered.
// The parser decodes a byte in a single pass from the input register into the
// output register. Synchronous active-low reset clears all control state.
// A stalled output holds its result; o_in_stall rises only when both the input
// and output registers are full and the output side stalls.
`include "assert_macros.svh"
module touch_report_point_parser
    import trpp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_report_start,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_has_point,
    output logic [3:0]         o_point_index,
    output logic [4:0]         o_finger_id,
    output logic signed [15:0] o_pos_x,
    output logic signed [15:0] o_pos_y,
    output logic [7:0]         o_pressure,
    output logic               o_last_point
);

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_byte;
    logic       r_start;
    logic       out_free;
    logic       advance;
    logic       in_take;
    logic       emit;
    t_result    result;
    t_result    out_result;

    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign n_in_valid = in_take || (r_in_valid && !advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byte  <= i_data_byte;
            r_start <= i_report_start;
        end
    end

    trpp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_byte   (r_byte),
        .i_start  (r_start),
        .o_emit   (emit),
        .o_result (result)
    );

    trpp_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (emit),
        .i_result (result),
        .i_stall  (i_out_stall),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_has_point   = out_result.has_point;
    assign o_point_index = out_result.point_index;
    assign o_finger_id   = out_result.finger_id;
    assign o_pos_x       = out_result.pos_x;
    assign o_pos_y       = out_result.pos_y;
    assign o_pressure    = out_result.pressure;
    assign o_last_point  = out_result.last_point;

    `TRPP_ASSERT(a_stall_cause, i_clk, i_rst_n,
        o_in_stall |-> (r_in_valid && o_out_valid && i_out_stall))
    `TRPP_ASSERT(a_emit_only_on_advance, i_clk, i_rst_n, emit |-> advance)
    `TRPP_ASSERT(a_item_kept, i_clk, i_rst_n,
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_byte)))

endmodule

/* verif/report_checker.sv */
// Checker for the touch report point parser: watches both channels, decodes
// each accepted byte into the points it should produce, and compares results.
// Depends on trpp_pkg for the report layout constants and the result struct.
module report_checker
    import trpp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_report_start,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_has_point,
    input  logic [3:0]         i_point_index,
    input  logic [4:0]         i_finger_id,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [7:0]         i_pressure,
    input  logic               i_last_point,
    output int                 o_mismatches,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] COUNT_MASK = 8'h1F;

    // parser state as seen from outside
    int          next_pos    = 0;
    int          report_len  = 0;
    bit          in_report   = 1'b0;
    int          points_want = 0;
    int          record_no   = 0;
    logic [39:0] record_buf  = '0;

    t_result     points_due[$];
    int          mism_cnt    = 0;

    function automatic void close_empty();
        t_result r;
        r            = '0;
        r.last_point = 1'b1;
        points_due.push_back(r);
        in_report = 1'b0;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic start);
        int      pos;
        int      n;
        int      fit;
        int      off;
        t_result r;
        if (start) begin
            in_report   = 1'b1;
            next_pos    = 0;
            report_len  = 0;
            points_want = 0;
            record_no   = 0;
            record_buf  = '0;
        end
        if (!in_report)
            return;
        pos      = next_pos;
        next_pos = (pos + 1) & 16'hFFFF;
        // bytes past the length close the report quietly
        if (pos > int'(POS_ID) && pos >= report_len) begin
            in_report = 1'b0;
            return;
        end
        if (pos == int'(POS_LEN_LO)) begin
            report_len = int'(b);
        end else if (pos == int'(POS_LEN_HI)) begin
            report_len = report_len | (int'(b) << 8);
            if (report_len == 0 || report_len == int'(LEN_NONE)) begin
                close_empty();
            end else begin
                if (report_len > MAX_REPORT)
                    report_len = MAX_REPORT;
                if (report_len < int'(LEN_MIN))
                    close_empty();
            end
        end else if (pos == int'(POS_ID)) begin
            if ((b == ID_BUTTON && report_len == BTN_BYTES) || b != ID_TOUCH ||
                report_len < HDR_BYTES)
                close_empty();
        end else if (pos == int'(POS_COUNT)) begin
            n   = int'(b & COUNT_MASK);
            fit = (report_len - HDR_BYTES) / REC_BYTES;
            if (n > fit)
                n = fit;
            if (n > RECORD_LIMIT)
                n = RECORD_LIMIT;
            if (n > OUTPUT_POINT_LIMIT)
                n = OUTPUT_POINT_LIMIT;
            points_want = n;
            record_no   = 0;
            if (n == 0)
                close_empty();
        end else if (pos >= HDR_BYTES) begin
            off = (pos - HDR_BYTES) % REC_BYTES;
            if (off == int'(OFF_CLEAR)) begin
                record_buf = '0;
            end else if (off <= int'(OFF_Y_HI)) begin
                record_buf = record_buf | (40'(b) << (8 * (off - 1)));
            end else if (off == int'(OFF_PRESSURE)) begin
                r.has_point   = 1'b1;
                r.point_index = 4'(record_no);
                r.finger_id   = record_buf[7:3];
                r.pos_x       = record_buf[23:8];
                r.pos_y       = record_buf[39:24];
                r.pressure    = b;
                r.last_point  = (record_no + 1) >= points_want;
                points_due.push_back(r);
                record_no = (record_no + 1) & 4'hF;
                if (r.last_point)
                    in_report = 1'b0;
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mism_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall)
                decode_byte(i_data_byte, i_report_start);
            if (i_out_valid && !i_out_stall) begin
                if (points_due.size() == 0) begin
                    $display("%0t: unexpected result, has_point %b last_point %b",
                             $time, i_has_point, i_last_point);
                    mism_cnt++;
                end else begin
                    r = points_due.pop_front();
                    check_field("has_point",   16'(r.has_point),   16'(i_has_point));
                    check_field("point_index", 16'(r.point_index), 16'(i_point_index));
                    check_field("finger_id",   16'(r.finger_id),   16'(i_finger_id));
                    check_field("pos_x",       r.pos_x,            i_pos_x);
                    check_field("pos_y",       r.pos_y,            i_pos_y);
                    check_field("pressure",    16'(r.pressure),    16'(i_pressure));
                    check_field("last_point",  16'(r.last_point),  16'(i_last_point));
                end
            end
        end
        o_pending    <= points_due.size();
        o_mismatches <= mism_cnt;
    end

endmodule

/* verif/tb_top.sv */
// Top of the touch report point parser testbench: clock, reset, report stimulus
// with bursty input and patterned output stall, and the final verdict.
// Depends on trpp_pkg, touch_report_point_parser and report_checker.
module tb_top;
    import trpp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {FLOW, LIGHT, HEAVY, TOGGLE, HOLD} t_stall_mode;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic [7:0]         data_byte    = 8'h00;
    logic               report_start = 1'b0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic               has_point;
    logic [3:0]         point_index;
    logic [4:0]         finger_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         pressure;
    logic               last_point;
    int                 mismatches;
    int                 pending;

    int burst_left = 0;
    int bytes_sent = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    touch_report_point_parser uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_data_byte    (data_byte),
        .i_report_start (report_start),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_has_point    (has_point),
        .o_point_index  (point_index),
        .o_finger_id    (finger_id),
        .o_pos_x        (pos_x),
        .o_pos_y        (pos_y),
        .o_pressure     (pressure),
        .o_last_point   (last_point)
    );

    report_checker chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_data_byte    (data_byte),
        .i_report_start (report_start),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_has_point    (has_point),
        .i_point_index  (point_index),
        .i_finger_id    (finger_id),
        .i_pos_x        (pos_x),
        .i_pos_y        (pos_y),
        .i_pressure     (pressure),
        .i_last_point   (last_point),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    // one item per call; a random gap, possibly empty, is inserted whenever the current burst runs out
    task automatic push_byte(input logic [7:0] b, input logic start);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
            gap        = $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        data_byte    <= b;
        report_start <= start;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic void add_header(ref logic [7:0] q[$], input logic [15:0] len,
                                       input logic [7:0] id, input logic [7:0] cnt);
        q.push_back(len[7:0]);
        q.push_back(len[15:8]);
        q.push_back(id);
        q.push_back(8'($urandom));
        q.push_back(8'($urandom));
        q.push_back(cnt);
        q.push_back(8'($urandom));
    endfunction

    function automatic void add_record(ref logic [7:0] q[$], input logic [7:0] meta,
                                       input logic [15:0] x, input logic [15:0] y,
                                       input logic [7:0] pres);
        q.push_back(8'($urandom));
        q.push_back(meta);
        q.push_back(x[7:0]);
        q.push_back(x[15:8]);
        q.push_back(y[7:0]);
        q.push_back(y[15:8]);
        q.push_back(pres);
        repeat (3) q.push_back(8'($urandom));
    endfunction

    function automatic logic [15:0] extreme_word();
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic send_bytes(input logic [7:0] q[$]);
        foreach (q[k])
            push_byte(q[k], k == 0);
        bytes_sent += q.size();
    endtask

    task automatic send_report(input logic [15:0] len, input logic [7:0] id,
                               input logic [7:0] cnt, input int nrec);
        logic [7:0] q[$];
        add_header(q, len, id, cnt);
        repeat (nrec)
            add_record(q, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
        send_bytes(q);
    endtask

    task automatic random_report();
        logic [7:0] q[$];
        logic [7:0] id;
        int         kind;
        int         len;
        int         eff;
        int         nrec;
        int         cnt;
        int         k;
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
            // touch report, sometimes with odd length or count, cut short or with extra bytes
            nrec = $urandom_range(0, RECORD_LIMIT);
            len  = HDR_BYTES + REC_BYTES * nrec;
            k    = $urandom_range(0, 9);
            if (k < 2) begin
                len += $urandom_range(1, REC_BYTES - 1);
            end else if (k == 2) begin
                len  = $urandom_range(MAX_REPORT + 1, 16'hFFFE);
                nrec = RECORD_LIMIT;
            end
            cnt = ($urandom_range(0, 2) != 0) ? nrec : $urandom_range(0, 31);
            add_header(q, 16'(len), ID_TOUCH, 8'(cnt) | 8'($urandom_range(0, 7) << 5));
            repeat (nrec)
                add_record(q, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
            eff = (len > MAX_REPORT) ? MAX_REPORT : len;
            while (q.size() < eff)
                q.push_back(8'($urandom));
            k = $urandom_range(0, 19);
            if (k < 3) begin
                // cut short; the next start drops what is left
                eff = $urandom_range(1, eff);
                while (q.size() > eff)
                    void'(q.pop_back());
            end else if (k < 6) begin
                repeat ($urandom_range(1, 6))
                    q.push_back(8'($urandom));
            end
            send_bytes(q);
        end else if (kind < 88) begin
            case ($urandom_range(0, 5))
                0:       len = 0;
                1:       len = 16'hFFFF;
                2:       len = $urandom_range(1, HDR_BYTES - 1);
                3:       len = BTN_BYTES;
                4:       len = $urandom_range(HDR_BYTES, MAX_REPORT);
                default: len = $urandom_range(0, 16'hFFFF);
            endcase
            case ($urandom_range(0, 3))
                0:       id = ID_BUTTON;
                1:       id = ID_TOUCH;
                default: id = 8'($urandom);
            endcase
            add_header(q, 16'(len), id, 8'($urandom));
            send_bytes(q);
        end else if (kind < 95) begin
            // loose bytes, mostly without a start
            repeat ($urandom_range(1, 12))
                push_byte(8'($urandom), $urandom_range(0, 7) == 0);
        end else begin
            nrec = $urandom_range(1, RECORD_LIMIT);
            add_header(q, 16'(HDR_BYTES + REC_BYTES * nrec), ID_TOUCH, 8'(nrec));
            repeat (nrec)
                add_record(q, ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00, extreme_word(),
                           extreme_word(), ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00);
            send_bytes(q);
        end
    endtask

    // output side: segments of different stall patterns, one long hold-off
    initial begin
        t_stall_mode mode;
        int          seg;
        int          cyc;
        bit          held;
        cyc  = 0;
        held = 1'b0;
        forever begin
            mode = t_stall_mode'($urandom_range(0, 3));
            seg  = $urandom_range(16, 160);
            if (!held && cyc >= 400) begin
                held = 1'b1;
                mode = HOLD;
                seg  = 150;
            end
            repeat (seg) begin
                @(posedge clk);
                cyc++;
                case (mode)
                    FLOW:    out_stall <= 1'b0;
                    LIGHT:   out_stall <= ($urandom_range(0, 3) == 0);
                    HEAVY:   out_stall <= ($urandom_range(0, 3) != 0);
                    TOGGLE:  out_stall <= cyc[0];
                    default: out_stall <= 1'b1;
                endcase
            end
        end
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [7:0] d[$];
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_report(16'h0000, ID_TOUCH, 8'd1, 0);
        send_report(16'hFFFF, ID_TOUCH, 8'd1, 0);
        send_report(16'd1, ID_TOUCH, 8'd1, 0);
        send_report(16'd2, ID_TOUCH, 8'd1, 0);
        send_report(16'd3, ID_TOUCH, 8'd1, 0);
        send_report(16'(BTN_BYTES), ID_BUTTON, 8'd1, 1);
        send_report(16'd17, ID_BUTTON, 8'd1, 1);
        send_report(16'd17, 8'hFE, 8'd1, 1);
        send_report(16'd17, ID_TOUCH, 8'd0, 1);
        send_report(16'd12, ID_TOUCH, 8'd2, 0);
        send_report(16'd17, ID_TOUCH, 8'hE1, 1);
        add_header(d, 16'd27, ID_TOUCH, 8'd2);
        add_record(d, 8'hFF, 16'h8000, 16'h7FFF, 8'hFF);
        add_record(d, 8'h00, 16'h7FFF, 16'h8000, 8'h00);
        send_bytes(d);
        send_report(16'hFFFE, ID_TOUCH, 8'hFF, RECORD_LIMIT);
        send_report(16'h0100, ID_TOUCH, 8'd3, 3);
        send_report(16'd27, ID_TOUCH, 8'd5, 2);
        send_report(16'd47, ID_TOUCH, 8'd4, 5);
        send_report(16'd36, ID_TOUCH, 8'd3, 3);
        // restart in the middle of a report, then stray bytes after a full one
        d.delete();
        add_header(d, 16'd37, ID_TOUCH, 8'd3);
        add_record(d, 8'h5A, 16'h1234, 16'hFEDC, 8'h80);
        send_bytes(d);
        send_report(16'd17, ID_TOUCH, 8'd1, 1);
        repeat (5)
            push_byte(8'($urandom), 1'b0);

        while (bytes_sent < 1500)
            random_report();

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* touch_report_point_parser.f */
+incdir+rtl
rtl/trpp_pkg.sv
rtl/trpp_parser.sv
rtl/trpp_out_reg.sv
rtl/touch_report_point_parser.sv
verif/report_checker.sv
verif/tb_top.sv
